### design/decimal_digit_display_writer_assert.svh
`ifndef DECIMAL_DIGIT_DISPLAY_WRITER_ASSERT_SVH
`define DECIMAL_DIGIT_DISPLAY_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define DDW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DDW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ddw_pkg.sv
`default_nettype none

package ddw_pkg;

    typedef struct packed {
        logic signed [27:0] value;
        logic [3:0]         digit_count;
    } t_in;

    typedef struct packed {
        logic       write_valid;
        logic [3:0] reg_address;
        logic [7:0] reg_data;
        logic [1:0] status;
        logic       last;
    } t_out;

    localparam logic signed [27:0] VALUE_MAX = 28'sd99999999;
    localparam logic signed [27:0] VALUE_MIN = -28'sd9999999;

    localparam logic [3:0] ADDR_NONE       = 4'h0;
    localparam logic [3:0] ADDR_SCAN_LIMIT = 4'hB;
    localparam logic [3:0] ADDR_SHUTDOWN   = 4'hC;

    localparam logic [7:0] DATA_SHUTDOWN_ON  = 8'h00;
    localparam logic [7:0] DATA_SHUTDOWN_OFF = 8'h01;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LEFTOVER = 2'd1;
    localparam logic [1:0] ST_ILLEGAL  = 2'd2;

    localparam logic [3:0] NO_COUNT = 4'd15;

    localparam int MAG_W = 27;

    // Reciprocal of ten scaled by two to the thirtieth, rounded up.
    localparam logic [MAG_W-1:0] DIV10_RECIP = 27'd107374183;
    localparam int DIV10_SHIFT = 30;

endpackage

`default_nettype wire

### design/ddw_div10.sv
`default_nettype none

module ddw_div10
    import ddw_pkg::*;
(
    input  wire logic [MAG_W-1:0] i_dividend,
    output logic      [MAG_W-1:0] o_quotient,
    output logic      [3:0]       o_remainder
);

    logic [2*MAG_W-1:0] w_prod;
    logic [2*MAG_W-DIV10_SHIFT-1:0] w_q;
    logic [MAG_W-1:0] w_q10;
    logic [MAG_W-1:0] w_rem;

    // The scaled reciprocal is exact for every dividend below two to the 27th.
    assign w_prod = (2*MAG_W)'(i_dividend) * (2*MAG_W)'(DIV10_RECIP);
    assign w_q    = w_prod[2*MAG_W-1:DIV10_SHIFT];
    assign w_q10  = MAG_W'({w_q, 3'b000}) + MAG_W'({w_q, 1'b0});
    assign w_rem  = i_dividend - w_q10;

    assign o_quotient  = MAG_W'(w_q);
    assign o_remainder = w_rem[3:0];

endmodule

`default_nettype wire

### design/decimal_digit_display_writer.sv
// Turns a signed value and a digit count into the register writes for an
// 8-digit seven-segment driver, least significant digit first, at most one write per
// output transfer. An input item is taken only while the block is idle; it
// then gives one output item per cycle while the output side keeps up: count
// digits plus up to two control writes, or one item with no write for an
// illegal input or a repeated zero count. Every digit comes from the single
// divide-by-ten unit, which is used once per digit.
// The next input transfer may be taken while the final result still waits.
`default_nettype none

`include "decimal_digit_display_writer_assert.svh"

module decimal_digit_display_writer
    import ddw_pkg::*;
#(
    parameter int MAX_DIGITS = 8
)
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXIT  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DIGIT = 3'd3;
    localparam logic [2:0] S_EMPTY = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [3:0]       r_shown, n_shown;
    logic [3:0]       r_count, n_count;
    logic [3:0]       r_idx, n_idx;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic             r_neg, n_neg;
    logic [1:0]       r_status, n_status;
    logic             r_out_valid;
    t_out             r_out;

    logic             w_accept;
    logic             w_load;
    logic             w_illegal;
    logic [27:0]      w_neg_value;
    logic [MAG_W-1:0] w_in_mag;
    logic [MAG_W-1:0] w_quot;
    logic [3:0]       w_rem;
    logic             w_gen_valid;
    t_out             w_gen;

    ddw_div10 u_div10 (
        .i_dividend  (r_mag),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load      = !r_out_valid || i_out_ready;
    assign w_gen_valid = (r_state != S_IDLE);

    assign w_illegal = (i_in.value > VALUE_MAX) || (i_in.value < VALUE_MIN)
                       || (i_in.digit_count > 4'(MAX_DIGITS));
    assign w_neg_value = 28'd0 - i_in.value;
    assign w_in_mag    = i_in.value[27] ? w_neg_value[MAG_W-1:0]
                                        : i_in.value[MAG_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_shown  = r_shown;
        n_count  = r_count;
        n_idx    = r_idx;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_status = r_status;
        w_gen    = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_count  = i_in.digit_count;
                    n_mag    = w_in_mag;
                    n_neg    = i_in.value[27];
                    n_idx    = 4'd1;
                    n_status = (w_in_mag != '0) ? ST_LEFTOVER : ST_OK;
                    if (w_illegal) begin
                        n_status = ST_ILLEGAL;
                        n_state  = S_EMPTY;
                    end else if (i_in.digit_count != r_shown) begin
                        n_shown = i_in.digit_count;
                        n_state = (r_shown == 4'd0) ? S_EXIT : S_SCAN;
                    end else if (i_in.digit_count == 4'd0) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_state = S_DIGIT;
                    end
                end
            end
            S_EXIT: begin
                w_gen.write_valid = 1'b1;
                w_gen.reg_address = ADDR_SHUTDOWN;
                w_gen.reg_data    = DATA_SHUTDOWN_OFF;
                if (w_load) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                w_gen.write_valid = 1'b1;
                if (r_count != 4'd0) begin
                    w_gen.reg_address = ADDR_SCAN_LIMIT;
                    w_gen.reg_data    = {4'd0, r_count - 4'd1};
                    if (w_load) begin
                        n_state = S_DIGIT;
                    end
                end else begin
                    w_gen.reg_address = ADDR_SHUTDOWN;
                    w_gen.reg_data    = DATA_SHUTDOWN_ON;
                    w_gen.status      = r_status;
                    w_gen.last        = 1'b1;
                    if (w_load) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIGIT: begin
                w_gen.write_valid = 1'b1;
                w_gen.reg_address = r_idx;
                w_gen.reg_data    = r_neg ? 8'(8'd0 - {4'd0, w_rem}) : {4'd0, w_rem};
                if (r_idx == r_count) begin
                    w_gen.last   = 1'b1;
                    w_gen.status = (w_quot != '0) ? ST_LEFTOVER : ST_OK;
                end
                if (w_load) begin
                    n_mag = w_quot;
                    n_idx = r_idx + 4'd1;
                    if (r_idx == r_count) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMPTY: begin
                w_gen.reg_address = ADDR_NONE;
                w_gen.status      = r_status;
                w_gen.last        = 1'b1;
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shown     <= NO_COUNT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_shown <= n_shown;
            if (w_load) begin
                r_out_valid <= w_gen_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count  <= n_count;
        r_idx    <= n_idx;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_status <= n_status;
        if (w_load) begin
            r_out <= w_gen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `DDW_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != S_IDLE,
        "accepted input produced no work")
    `DDW_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, w_load && w_gen_valid && w_gen.last,
        r_state == S_IDLE, "sequencer did not finish after last transfer")
    `DDW_ASSERT_NOW(a_shown_range, i_clk, i_rst_n, 1'b1,
        r_shown <= 4'(MAX_DIGITS) || r_shown == NO_COUNT, "stored digit count out of range")
    `DDW_ASSERT_NOW(a_digit_index, i_clk, i_rst_n, r_state == S_DIGIT,
        r_idx >= 4'd1 && r_idx <= r_count, "digit index outside the digit count")
    `DDW_ASSERT_NOW(a_status_last, i_clk, i_rst_n, o_out_valid && !o_out.last,
        o_out.status == ST_OK, "status set on a non-final transfer")

endmodule

`default_nettype wire
